### sv/lru_key_value_cache_defines.svh
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked at every rising clock edge outside reset.
`define LKV_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property checked in the cycle after a trigger.
`define LKV_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) else $error(msg);
`else
`define LKV_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define LKV_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg)
`endif

`endif

### sv/lru_kv_pkg.sv
// Shared constants, types and codes for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lru_kv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W  = 5;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [VAL_W-1:0]       val_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [RANK_W-1:0]      rank_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [MAX_ENTRIES-1:0] vld_t;
  typedef key_t  [MAX_ENTRIES-1:0] key_arr_t;
  typedef val_t  [MAX_ENTRIES-1:0] val_arr_t;
  typedef rank_t [MAX_ENTRIES-1:0] rank_arr_t;

  // Read value returned by a get that misses
  localparam val_t READ_MISS = '1;

  // Search results handed from the lookup to the update logic
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    idx_t victim_idx;
    idx_t free_idx;
  } lookup_t;

endpackage
`default_nettype wire

### sv/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: key, value; tuser: op
//  out_    | out | out_tvalid / out_tready| tdata: read_value; tuser: found
//  cfg_    | in  | cfg_wr_en              | cfg_wr_data: capacity
//
// One beat per cycle sustained while out_tready is high; a taken beat goes through
// the input register, then match and update, into the result register.
// The store state is updated in the same cycle the result register loads, so
// back-to-back beats see each other's effects.
// Reset (synchronous, rst_n low) and any capacity write empty the store.
// A stalled result register holds its beat; in_tready drops only while both
// stages are full and out_tready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_value_cache_defines.svh"
module lru_key_value_cache (
  input  wire        clk,
  input  wire        rst_n,
  // cfg
  input  wire        cfg_wr_en,
  input  wire [4:0]  cfg_wr_data,   // capacity
  // input stream
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [63:0] in_tdata,      // [31:0] key, [63:32] value
  input  wire        in_tuser,      // [0] op
  // result stream
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata,    // [31:0] read_value
  output logic       out_tuser      // [0] found
);
  import lru_kv_pkg::*;

  // input register
  logic s1_vld_r;
  op_t  s1_op_r;
  key_t s1_key_r;
  val_t s1_val_r;

  // result register
  logic out_vld_r;
  logic out_found_r;
  val_t out_data_r;

  // store
  logic [CAP_W-1:0] capacity_r;
  key_arr_t  keys_r,  keys_nxt;
  val_arr_t  vals_r,  vals_nxt;
  vld_t      valid_r, valid_nxt;
  rank_arr_t rank_r,  rank_nxt;
  cnt_t      count_r, count_nxt;

  lookup_t lk;
  logic    advance;
  logic    in_fire;
  logic    is_put;
  logic    evict;
  logic    touch;
  idx_t    tgt_idx;
  rank_t   hit_rank;
  val_t    hit_val;
  cnt_t    live_cap;
  logic    res_found;
  val_t    res_data;

  // handshakes
  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

  lru_kv_lookup u_lookup (
    .keys_i  (keys_r),
    .valid_i (valid_r),
    .ranks_i (rank_r),
    .count_i (count_r),
    .key_i   (s1_key_r),
    .lk_o    (lk)
  );

  // capacity zero acts as one, large values saturate
  always_comb begin
    if (capacity_r == '0) begin
      live_cap = cnt_t'(1);
    end else if (32'(capacity_r) > MAX_ENTRIES) begin
      live_cap = cnt_t'(MAX_ENTRIES);
    end else begin
      live_cap = cnt_t'(capacity_r);
    end
  end

  // slot selection and result
  always_comb begin
    is_put   = (s1_op_r == OP_PUT);
    evict    = (count_r >= live_cap);
    hit_rank = rank_r[lk.hit_idx];
    hit_val  = vals_r[lk.hit_idx];
    if (lk.hit) begin
      tgt_idx = lk.hit_idx;
    end else if (evict) begin
      tgt_idx = lk.victim_idx;
    end else begin
      tgt_idx = lk.free_idx;
    end
    touch     = advance && (lk.hit || is_put);
    res_found = lk.hit;
    if (is_put) begin
      res_data = '0;
    end else if (lk.hit) begin
      res_data = hit_val;
    end else begin
      res_data = READ_MISS;
    end
  end

  // store next state: target goes most recent, younger entries age by one
  always_comb begin
    keys_nxt  = keys_r;
    vals_nxt  = vals_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    if (touch) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (idx_t'(i) == tgt_idx) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
        end else if (valid_r[i] && (!lk.hit || (rank_r[i] < hit_rank))) begin
          rank_nxt[i] = rank_r[i] + rank_t'(1);
        end
      end
      if (is_put) begin
        keys_nxt[tgt_idx] = s1_key_r;
        vals_nxt[tgt_idx] = s1_val_r;
      end
      // an eviction frees and refills one slot, count unchanged
      if (is_put && !lk.hit && !evict) begin
        count_nxt = count_r + cnt_t'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      capacity_r <= CAP_RESET;
      valid_r    <= '0;
      rank_r     <= '0;
      count_r    <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
        valid_r    <= '0;
        rank_r     <= '0;
        count_r    <= '0;
      end else begin
        valid_r <= valid_nxt;
        rank_r  <= rank_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    keys_r <= keys_nxt;
    vals_r <= vals_nxt;
    if (in_fire) begin
      s1_op_r  <= op_t'(in_tuser);
      s1_key_r <= in_tdata[KEY_W-1:0];
      s1_val_r <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (advance) begin
      out_found_r <= res_found;
      out_data_r  <= res_data;
    end
  end

  // checks
  `LKV_ASSERT_ALWAYS(a_count_matches_valid, clk, rst_n, $countones(valid_r) == 32'(count_r), "entry count disagrees with valid bits")
  `LKV_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_wr_en, (count_r == '0) && (valid_r == '0), "capacity write did not clear the store")
  `LKV_ASSERT_NEXT(a_evict_keeps_count, clk, rst_n, advance && !cfg_wr_en && is_put && !lk.hit && evict, count_r == $past(count_r), "eviction changed the entry count")

endmodule
`default_nettype wire

### sv/lru_kv_lookup.sv
// Parallel tag match, LRU victim pick and free slot search.
`timescale 1ns / 1ps
`default_nettype none
module lru_kv_lookup (
  input  wire lru_kv_pkg::key_arr_t  keys_i,
  input  wire lru_kv_pkg::vld_t      valid_i,
  input  wire lru_kv_pkg::rank_arr_t ranks_i,
  input  wire lru_kv_pkg::cnt_t      count_i,
  input  wire lru_kv_pkg::key_t      key_i,
  output lru_kv_pkg::lookup_t        lk_o
);
  import lru_kv_pkg::*;

  always_comb begin
    lk_o = '0;
    // key match, one comparator per entry; highest match wins
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (valid_i[i] && (keys_i[i] == key_i)) begin
        lk_o.hit     = 1'b1;
        lk_o.hit_idx = idx_t'(i);
      end
    end
    // least recent entry holds rank count-1
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (valid_i[i] && ((32'(ranks_i[i]) + 32'd1) == 32'(count_i))) begin
        lk_o.victim_idx = idx_t'(i);
      end
    end
    // lowest-numbered invalid slot
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        lk_o.free_idx = idx_t'(i);
      end
    end
  end

endmodule
`default_nettype wire

### verif/tb_lru_key_value_cache.sv
// Self-checking testbench for the LRU key-value cache: directed and random get/put traffic.
`timescale 1ns / 1ps
module tb_lru_key_value_cache;
  import lru_kv_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int POOL_MAX    = 24;

  typedef struct {
    logic found;
    val_t read_value;
  } access_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata = '0;     // [31:0] key, [63:32] value
  logic              in_tuser = 1'b0;   // [0] op
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;         // [31:0] read_value
  logic              out_tuser;         // [0] found

  // Shadow copy of the cache contents
  key_t              cache_keys  [MAX_ENTRIES];
  val_t              cache_vals  [MAX_ENTRIES];
  logic              cache_valid [MAX_ENTRIES];
  rank_t             cache_rank  [MAX_ENTRIES];
  cnt_t              cache_count;
  logic [CAP_W-1:0]  cache_capacity;

  access_result_t    pending_reads[$];
  int                error_count = 0;
  int                stall_cycles = 0;
  int                in_idle_pct = 0;
  int                out_idle_pct = 0;

  lru_key_value_cache i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cache predictor
  // ---------------------------------------------------------------------------
  function automatic int live_limit(logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(cap);
  endfunction

  function automatic void clear_cache();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_rank[i]  = '0;
      cache_keys[i]  = '0;
      cache_vals[i]  = '0;
    end
    cache_count = '0;
  endfunction

  // Move slot s to the front; valid entries newer than limit age by one
  function automatic void make_newest(int s, int limit);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cache_valid[i] && i != s && int'(cache_rank[i]) < limit)
        cache_rank[i] = cache_rank[i] + 1'b1;
    end
    cache_rank[s] = '0;
  endfunction

  function automatic access_result_t cache_access(op_t op, key_t key, val_t val);
    access_result_t res;
    int hit_slot;
    int slot;
    hit_slot = -1;
    slot = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cache_valid[i] && cache_keys[i] == key) hit_slot = i;
    end

    // Lookup
    if (op == OP_GET) begin
      if (hit_slot >= 0) begin
        res.found      = 1'b1;
        res.read_value = cache_vals[hit_slot];
        make_newest(hit_slot, int'(cache_rank[hit_slot]));
      end else begin
        res.found      = 1'b0;
        res.read_value = READ_MISS;
      end
      return res;
    end

    res.read_value = '0;
    // Update in place
    if (hit_slot >= 0) begin
      res.found = 1'b1;
      cache_vals[hit_slot] = val;
      make_newest(hit_slot, int'(cache_rank[hit_slot]));
      return res;
    end

    // Insert: evict the oldest when full, else take the lowest free slot
    res.found = 1'b0;
    if (int'(cache_count) >= live_limit(cache_capacity)) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (cache_valid[i] && int'(cache_rank[i]) + 1 == int'(cache_count)) slot = i;
      end
      if (slot < 0) slot = 0;
      cache_valid[slot] = 1'b0;
      cache_count = cache_count - 1'b1;
    end else begin
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
        if (!cache_valid[i]) slot = i;
      end
      if (slot < 0) slot = 0;
    end
    cache_keys[slot]  = key;
    cache_vals[slot]  = val;
    cache_valid[slot] = 1'b1;
    make_newest(slot, MAX_ENTRIES + 1);
    cache_count = cache_count + 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_access(op_t op, key_t key, val_t val);
    access_result_t exp_res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    exp_res = cache_access(op, key, val);
    pending_reads.insert(pending_reads.size(), exp_res);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // Capacity is only written with the pipeline empty
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cache_capacity = cap;
    clear_cache();
  endtask

  // Receiver backpressure
  initial begin
    forever begin
      @(posedge clk);
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result beat: found %0b read_value %h", out_tuser, out_tdata);
        error_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tuser);
          error_count++;
        end
        if (out_tdata !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_tdata);
          error_count++;
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Misses on an empty store, inserts, hits and updates at the key/value extremes
  task automatic test_hit_and_miss();
    send_access(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_access(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Capacity write empties the store; a touched entry survives eviction
  task automatic test_eviction_order();
    write_capacity(5'd2);
    send_access(OP_GET, 32'h8000_0000, 32'h0);
    send_access(OP_PUT, 32'h0000_00A1, 32'h0000_0001);
    send_access(OP_PUT, 32'h0000_00B2, 32'h0000_0002);
    send_access(OP_GET, 32'h0000_00A1, 32'h0);
    send_access(OP_PUT, 32'h0000_00C3, 32'h0000_0003);
    send_access(OP_GET, 32'h0000_00B2, 32'h0);
    send_access(OP_GET, 32'h0000_00A1, 32'h0);
    send_access(OP_GET, 32'h0000_00C3, 32'h0);
  endtask

  // Capacity zero behaves as a single entry
  task automatic test_capacity_floor();
    write_capacity(5'd0);
    send_access(OP_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
    send_access(OP_PUT, 32'hAAAA_5555, 32'h5555_AAAA);
    send_access(OP_GET, 32'h5555_AAAA, 32'h0);
    send_access(OP_GET, 32'hAAAA_5555, 32'h0);
  endtask

  // Random gets/puts over a key pool a little larger than the capacity,
  // so hits, updates and evictions all happen, plus some cold keys
  task automatic test_random_mix(int n_items, logic [CAP_W-1:0] cap);
    key_t key_pool[POOL_MAX];
    int   pool_size;
    key_t key;
    op_t  op;
    write_capacity(cap);
    pool_size = live_limit(cap) + 1 + $urandom_range(4);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < 80) key = key_pool[$urandom_range(pool_size - 1)];
      else key = $urandom;
      op = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
      send_access(op, key, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    clear_cache();
    cache_capacity = CAP_RESET;

    // Sender mostly busy, receiver mostly stalled
    in_idle_pct  = 12;
    out_idle_pct = 78;
    test_hit_and_miss();
    test_eviction_order();
    test_capacity_floor();
    test_random_mix(158, 5'd31);
    test_random_mix(158, 5'd16);
    test_random_mix(158, 5'd3);

    // Sender mostly idle, receiver mostly ready
    in_idle_pct  = 78;
    out_idle_pct = 12;
    test_random_mix(158, 5'd1);
    test_random_mix(158, 5'd0);
    test_random_mix(158, 5'd8);

    // Full rate
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_mix(158, 5'd17);
    test_random_mix(158, 5'd16);
    test_random_mix(158, 5'($urandom_range(31)));

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
